// File: design/aral_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range allocator package
// Shared sizes, command and status codes, controller states and the
// control and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aral_pkg;

   localparam int FREE_ENTRIES = 32;
   localparam int IDX_W        = $clog2(FREE_ENTRIES);
   localparam int CNT_W        = $clog2(FREE_ENTRIES + 2);
   localparam int MEM_AW       = IDX_W + 1;
   localparam int AW           = 48;
   localparam int PS_W         = 5;

   localparam logic [1:0] CMD_ANY     = 2'd0;
   localparam logic [1:0] CMD_EXACT   = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_UNUSABLE  = 2'd3;

   localparam logic [1:0] REG_BASE   = 2'd0;
   localparam logic [1:0] REG_LENGTH = 2'd1;
   localparam logic [1:0] REG_SHIFT  = 2'd2;

   localparam logic [PS_W-1:0] SHIFT_RESET = 5'd12;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROUND,
      S_BOUND,
      S_SEARCH,
      S_SPLIT,
      S_BUILD,
      S_FLUSH,
      S_DONE
   } aral_state_type;

   typedef struct packed {
      logic [AW-1:0] s;
      logic [AW-1:0] l;
   } aral_entry_type;

   typedef struct packed {
      logic load;
      logic round;
      logic bound;
      logic search;
      logic split;
      logic build;
      logic flush;
   } aral_ctl_type;

   typedef struct packed {
      logic finish;
      logic to_split;
      logic build_done;
   } aral_stat_type;

endpackage

// File: design/address_range_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range allocator
// First-fit free list of address ranges with exact carve-out, release and
// coalescing of adjacent ranges, kept sorted in a two-bank table memory.
// ----------------------------------------------------------------------------
// A request passes the round, bound and search states, then split, rebuild
// and flush if it changes the table, then the reply. Search and rebuild each
// read one table entry per cycle from the single read port; the rebuild
// pauses while it inserts a split piece. One request at a time: busy is high
// from acceptance to the response strobe, and the response cannot be stalled.
// Reset and any register write reload the table to one whole-region range.
module address_range_allocator (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_cmd,
   input  logic [aral_pkg::AW-1:0] req_size,
   input  logic [aral_pkg::AW-1:0] req_addr,
   output logic                    rsp_valid,
   output logic [aral_pkg::AW-1:0] rsp_grant_addr,
   output logic [aral_pkg::AW-1:0] rsp_grant_size,
   output logic [1:0]              rsp_status,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [aral_pkg::AW-1:0] csr_wdata
);
   import aral_pkg::*;

   aral_ctl_type  ctl;
   aral_stat_type stat;

   aral_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .ctl       (ctl),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   aral_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_cmd    (req_cmd),
      .req_size   (req_size),
      .req_addr   (req_addr),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .grant_addr (rsp_grant_addr),
      .grant_size (rsp_grant_size),
      .status     (rsp_status)
   );

endmodule

// File: design/aral_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range allocator controller
// Sequences one request through rounding, search, split, rebuild and reply.
// ----------------------------------------------------------------------------
module aral_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  aral_pkg::aral_stat_type stat,
   output aral_pkg::aral_ctl_type  ctl,
   output logic                   busy,
   output logic                   rsp_valid
);
   import aral_pkg::*;

   aral_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            ctl.round = 1'b1;
            state_in  = S_BOUND;
         end
         S_BOUND: begin
            ctl.bound = 1'b1;
            state_in  = S_SEARCH;
         end
         S_SEARCH: begin
            ctl.search = 1'b1;
            if (stat.finish) begin
               state_in = S_DONE;
            end else if (stat.to_split) begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            ctl.split = 1'b1;
            state_in  = S_BUILD;
         end
         S_BUILD: begin
            ctl.build = 1'b1;
            if (stat.build_done) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            ctl.flush = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but controller did not go busy");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response strobe longer than one cycle");
   a_build_holds: assert property (@(posedge clock) disable iff (reset)
      ctl.build && !stat.build_done |=> ctl.build)
      else $error("rebuild left before it was complete");
`endif

endmodule

// File: design/aral_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range allocator datapath
// Holds the region registers, the two-bank range table memory, the search
// compare, the split arithmetic and the streaming merge into the idle bank.
// ----------------------------------------------------------------------------
module aral_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  aral_pkg::aral_ctl_type           ctl,
   output aral_pkg::aral_stat_type          stat,
   input  logic [1:0]                       req_cmd,
   input  logic [aral_pkg::AW-1:0]          req_size,
   input  logic [aral_pkg::AW-1:0]          req_addr,
   input  logic                             csr_we,
   input  logic [1:0]                       csr_index,
   input  logic [aral_pkg::AW-1:0]          csr_wdata,
   output logic [aral_pkg::AW-1:0]          grant_addr,
   output logic [aral_pkg::AW-1:0]          grant_size,
   output logic [1:0]                       status
);
   import aral_pkg::*;

   localparam logic [AW+1:0] LIMIT = {2'b01, {AW{1'b0}}};

   // Configuration
   logic [AW-1:0]   base_ff, base_in, rlen_ff, rlen_in;
   logic [PS_W-1:0] shift_ff, shift_in;
   logic            reload;
   logic [AW:0]     room;
   logic [AW-1:0]   clip_len;

   // Request
   logic [1:0]    cmd_ff;
   logic [AW-1:0] size_ff, addr_ff;
   logic [AW:0]   req_ff, page_mask;
   logic [AW+1:0] end_ff;

   // Table
   aral_entry_type      mem [2*FREE_ENTRIES];
   aral_entry_type      rd_ff, mem_wd;
   logic                mem_we;
   logic [MEM_AW-1:0]   mem_wa;
   logic                bank_ff, bank_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;

   // Search and split
   logic [IDX_W-1:0] hit_ff;
   logic [AW-1:0]    p_ff, l_ff;
   logic [AW:0]      top_ff, top;
   logic             old_avail, is_rel, quick_ok, quick_bad, hit;
   logic             rm_ff;
   aral_entry_type   a_ff, b_ff;
   logic             a_v_ff, b_v_ff;

   // Merge
   aral_entry_type   acc_ff, sel;
   logic             acc_v_ff, sel_v, adv, take_a, take_b, join_ok;
   logic             build_done;
   logic [AW:0]      acc_end, sum_l;
   logic [CNT_W-1:0] oc_ff, oc_in, oc_fin;
   logic             commit;

   // Result
   logic [AW-1:0] g_addr_ff, g_size_ff;
   logic [1:0]    status_ff;

   assign grant_addr = g_addr_ff;
   assign grant_size = g_size_ff;
   assign status     = status_ff;

   // ---------------- configuration ----------------
   always_comb begin
      base_in  = base_ff;
      rlen_in  = rlen_ff;
      shift_in = shift_ff;
      reload   = 1'b0;
      if (csr_we) begin
         case (csr_index)
            REG_BASE: begin
               base_in = csr_wdata;
               reload  = 1'b1;
            end
            REG_LENGTH: begin
               rlen_in = csr_wdata;
               reload  = 1'b1;
            end
            REG_SHIFT: begin
               shift_in = csr_wdata[PS_W-1:0];
               reload   = 1'b1;
            end
            default: begin
               reload = 1'b0;
            end
         endcase
      end
      // The region is clipped so that it does not extend past the top of the address space.
      room     = {1'b1, {AW{1'b0}}} - {1'b0, base_in};
      clip_len = ({1'b0, rlen_in} > room) ? room[AW-1:0] : rlen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= '0;
         rlen_ff  <= '0;
         shift_ff <= SHIFT_RESET;
      end else begin
         base_ff  <= base_in;
         rlen_ff  <= rlen_in;
         shift_ff <= shift_in;
      end
   end

   // ---------------- search ----------------
   always_comb begin
      old_avail = idx_ff < count_ff;
      is_rel    = cmd_ff == CMD_RELEASE;
      top       = {1'b0, rd_ff.s} + {1'b0, rd_ff.l};
      quick_ok  = (cmd_ff == CMD_NONE) || (is_rel && size_ff == '0);
      quick_bad = (cmd_ff == CMD_EXACT || is_rel) && (end_ff > LIMIT);
      if (cmd_ff == CMD_ANY) begin
         hit = old_avail && ({1'b0, rd_ff.l} >= req_ff);
      end else begin
         hit = old_avail && (rd_ff.s <= addr_ff) && (top >= end_ff[AW:0]);
      end
      stat.finish     = quick_ok || quick_bad || (!is_rel && !old_avail);
      stat.to_split   = is_rel || hit;
      stat.build_done = build_done;
      page_mask       = ({{AW{1'b0}}, 1'b1} << shift_ff) - {{AW{1'b0}}, 1'b1};
   end

   // ---------------- rebuild selection and merge ----------------
   always_comb begin
      sel        = a_ff;
      sel_v      = 1'b0;
      adv        = 1'b0;
      take_a     = 1'b0;
      take_b     = 1'b0;
      build_done = 1'b0;
      // Old entries stream in order; a pending piece goes in ahead of the
      // first old entry that starts strictly above it.
      if (old_avail && rm_ff && idx_ff[IDX_W-1:0] == hit_ff) begin
         adv = 1'b1;
      end else if (a_v_ff && (!old_avail || rd_ff.s > a_ff.s)) begin
         sel    = a_ff;
         sel_v  = 1'b1;
         take_a = 1'b1;
      end else if (!a_v_ff && b_v_ff && (!old_avail || rd_ff.s > b_ff.s)) begin
         sel    = b_ff;
         sel_v  = 1'b1;
         take_b = 1'b1;
      end else if (old_avail) begin
         sel   = rd_ff;
         sel_v = 1'b1;
         adv   = 1'b1;
      end else begin
         build_done = 1'b1;
      end
      acc_end = {1'b0, acc_ff.s} + {1'b0, acc_ff.l};
      sum_l   = {1'b0, acc_ff.l} + {1'b0, sel.l};
      join_ok = acc_v_ff && (acc_end == {1'b0, sel.s}) && !sum_l[AW];
      oc_in   = oc_ff + CNT_W'(1);
      oc_fin  = oc_ff + CNT_W'(acc_v_ff);
      commit  = oc_fin <= CNT_W'(FREE_ENTRIES);
   end

   // ---------------- table memory ports ----------------
   always_comb begin
      mem_we = 1'b0;
      mem_wa = {~bank_ff, oc_ff[IDX_W-1:0]};
      mem_wd = acc_ff;
      if (reset) begin
         mem_we = 1'b1;
         mem_wa = '0;
         mem_wd = '0;
      end else if (reload) begin
         mem_we = 1'b1;
         mem_wa = {bank_ff, {IDX_W{1'b0}}};
         mem_wd = '{s: base_in, l: clip_len};
      end else if (((ctl.build && sel_v && !join_ok) || ctl.flush) && acc_v_ff) begin
         mem_we = oc_ff < CNT_W'(FREE_ENTRIES);
      end

      idx_in = '0;
      if (ctl.search && !stat.finish && !stat.to_split) begin
         idx_in = idx_ff + CNT_W'(1);
      end else if (ctl.build) begin
         idx_in = adv ? idx_ff + CNT_W'(1) : idx_ff;
      end

      bank_in  = bank_ff;
      count_in = count_ff;
      if (reload) begin
         count_in = CNT_W'(1);
      end else if (ctl.flush && commit) begin
         bank_in  = ~bank_ff;
         count_in = oc_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[{bank_ff, idx_in[IDX_W-1:0]}];
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         count_ff  <= CNT_W'(1);
         idx_ff    <= '0;
         status_ff <= ST_OK;
         acc_v_ff  <= 1'b0;
         a_v_ff    <= 1'b0;
         b_v_ff    <= 1'b0;
         rm_ff     <= 1'b0;
         oc_ff     <= '0;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (ctl.load) begin
            status_ff <= ST_OK;
         end else if (ctl.search) begin
            if (quick_ok) begin
               status_ff <= ST_OK;
            end else if (quick_bad) begin
               status_ff <= ST_UNUSABLE;
            end else if (!is_rel && !old_avail) begin
               status_ff <= (cmd_ff == CMD_ANY) ? ST_NO_FIT : ST_UNUSABLE;
            end
         end else if (ctl.flush && !commit) begin
            status_ff <= ST_FULL;
         end
         if (ctl.split) begin
            rm_ff    <= !is_rel;
            oc_ff    <= '0;
            acc_v_ff <= 1'b0;
            case (cmd_ff)
               CMD_ANY: begin
                  a_v_ff <= {1'b0, l_ff} > req_ff;
                  b_v_ff <= 1'b0;
               end
               CMD_EXACT: begin
                  a_v_ff <= addr_ff > p_ff;
                  b_v_ff <= end_ff[AW:0] < top_ff;
               end
               CMD_RELEASE: begin
                  a_v_ff <= 1'b1;
                  b_v_ff <= 1'b0;
               end
               default: begin
                  a_v_ff <= 1'b0;
                  b_v_ff <= 1'b0;
               end
            endcase
         end else if (ctl.build) begin
            if (take_a) begin
               a_v_ff <= 1'b0;
            end
            if (take_b) begin
               b_v_ff <= 1'b0;
            end
            if (sel_v) begin
               acc_v_ff <= 1'b1;
               if (!join_ok && acc_v_ff) begin
                  oc_ff <= oc_in;
               end
            end
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff    <= (req_cmd == CMD_EXACT && req_addr == '0) ? CMD_ANY : req_cmd;
         size_ff   <= req_size;
         addr_ff   <= req_addr;
         g_addr_ff <= '0;
         g_size_ff <= '0;
      end
      if (ctl.round) begin
         req_ff <= ({1'b0, size_ff} + page_mask) & ~page_mask;
      end
      if (ctl.bound) begin
         end_ff <= {2'b00, addr_ff} +
                   (is_rel ? {2'b00, size_ff} : {1'b0, req_ff});
      end
      if (ctl.search && hit) begin
         hit_ff <= idx_ff[IDX_W-1:0];
         p_ff   <= rd_ff.s;
         l_ff   <= rd_ff.l;
         top_ff <= top;
      end
      if (ctl.split) begin
         case (cmd_ff)
            CMD_ANY: begin
               a_ff.s <= p_ff + req_ff[AW-1:0];
               a_ff.l <= l_ff - req_ff[AW-1:0];
            end
            CMD_EXACT: begin
               a_ff.s <= p_ff;
               a_ff.l <= addr_ff - p_ff;
            end
            default: begin
               a_ff.s <= addr_ff;
               a_ff.l <= size_ff;
            end
         endcase
         b_ff.s <= end_ff[AW-1:0];
         b_ff.l <= top_ff[AW-1:0] - end_ff[AW-1:0];
      end
      if (ctl.build && sel_v) begin
         if (join_ok) begin
            acc_ff.l <= sum_l[AW-1:0];
         end else begin
            acc_ff <= sel;
         end
      end
      if (ctl.flush && commit && !is_rel) begin
         g_addr_ff <= (cmd_ff == CMD_ANY) ? p_ff : addr_ff;
         g_size_ff <= req_ff[AW-1:0];
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FREE_ENTRIES))
      else $error("range count above table size");
   a_full_no_grant: assert property (@(posedge clock) disable iff (reset)
      status_ff == ST_FULL |-> g_size_ff == '0 && g_addr_ff == '0)
      else $error("grant reported together with table full");
   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      ctl.build |-> oc_ff <= CNT_W'(FREE_ENTRIES + 1))
      else $error("rebuild produced too many ranges");
   a_commit_count: assert property (@(posedge clock) disable iff (reset)
      ctl.flush && commit |=> count_ff == $past(oc_fin) && bank_ff != $past(bank_ff))
      else $error("commit did not take the rebuilt table");
`endif

endmodule
